FILE: hw/rtl/ppk_pkg.sv
// ----------------------------------------------------------------------------
// ppk_pkg
// Shared types, constants and helpers of the page-mode 2bpp pixel packer.
// ----------------------------------------------------------------------------
`default_nettype none

package ppk_pkg;

  localparam int unsigned PIXEL_W      = 8;
  localparam int unsigned CFG_DATA_W   = 8;
  localparam int unsigned CFG_INDEX_W  = 1;
  localparam int unsigned BYTE_ADDR_W  = 12;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned PLANE_BITS   = 7;
  localparam int unsigned ENTRY_W      = 2 * PLANE_BITS;
  localparam int unsigned ADDR_CALC_W  = 24;

  // Grey pixel: keep bits 7 and 6 only.
  localparam int unsigned PIX_SHIFT    = 6;
  localparam logic [1:0]  PIX_MASK     = 2'b11;

  // Rows per page band.
  localparam int unsigned BAND_ROWS    = 8;
  localparam int unsigned BAND_LOG     = $clog2(BAND_ROWS);
  localparam logic [BAND_LOG-1:0] BAND_TOP_ROW = BAND_LOG'(BAND_ROWS - 1);
  localparam logic [BAND_LOG-1:0] BAND_BOTTOM_ROW = '0;

  localparam logic [CFG_DATA_W-1:0] RESET_WIDTH  = 8'd96;
  localparam logic [CFG_DATA_W-1:0] RESET_HEIGHT = 8'd64;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_index_t;

  // Work passed from the address/counter stage to the merge stage.
  typedef struct packed {
    logic                   valid;
    logic                   emit;      // bottom row of the band: close the column
    logic                   fresh;     // first row of the band seen: ignore stored bits
    logic                   last;      // final pixel of the frame
    logic                   hi;
    logic                   lo;
    logic [BAND_LOG-1:0]    row_in_band;
    logic [BYTE_ADDR_W-1:0] addr;      // even address of the high-plane byte
  } stage_t;

  // Last valid index of a dimension: zero reads as one, clamp to the maximum.
  function automatic int unsigned dim_last(input logic [CFG_DATA_W-1:0] v,
                                           input int unsigned max_dim);
    int unsigned d;
    d = 32'(v);
    if (d == 0) d = 1;
    if (d > max_dim) d = max_dim;
    return d - 1;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/ppk_ram.sv
// ----------------------------------------------------------------------------
// ppk_ram
// Generic single-write, single-read RAM with registered read (read-first).
// ----------------------------------------------------------------------------
`default_nettype none

module ppk_ram #(
  parameter int unsigned WIDTH = 14,
  parameter int unsigned DEPTH = 128,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ppk_sched.sv
// ----------------------------------------------------------------------------
// ppk_sched
// Frame geometry registers, row/column counters and the address stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ppk_sched import ppk_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 128,
  parameter int unsigned MAX_HEIGHT = 128,
  localparam int unsigned COL_W     = $clog2(MAX_WIDTH),
  localparam int unsigned ROW_W     = $clog2(MAX_HEIGHT)
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_wr_en,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   in_valid,
  input  wire logic                   hold,
  input  wire logic [PIXEL_W-1:0]     pixel_value,
  output logic                        rd_en,
  output logic      [COL_W-1:0]       rd_addr,
  output stage_t                      stage,
  output logic      [COL_W-1:0]       stage_col
);

  logic [COL_W-1:0] w_last;
  logic [ROW_W-1:0] h_last;
  logic [COL_W-1:0] col_cnt;
  logic [ROW_W-1:0] row_cnt;
  logic [COL_W-1:0] col_cnt_next;
  logic [ROW_W-1:0] row_cnt_next;
  logic [COL_W-1:0] cfg_w_last;
  logic [ROW_W-1:0] cfg_h_last;
  logic             accept;
  logic [ADDR_CALC_W-1:0] addr_sum;
  logic [1:0]       pix;
  stage_t           stage_next;

  assign accept     = in_valid && !hold;
  assign rd_en      = accept;
  assign rd_addr    = col_cnt;
  assign cfg_w_last = COL_W'(dim_last(cfg_data, MAX_WIDTH));
  assign cfg_h_last = ROW_W'(dim_last(cfg_data, MAX_HEIGHT));

  always_comb begin
    if (col_cnt == w_last) begin
      col_cnt_next = '0;
      row_cnt_next = (row_cnt == '0) ? h_last : row_cnt - ROW_W'(1);
    end else begin
      col_cnt_next = col_cnt + COL_W'(1);
      row_cnt_next = row_cnt;
    end
  end

  // band * width + column, doubled for the plane pair
  assign addr_sum = (ADDR_CALC_W'(row_cnt) >> BAND_LOG) *
                    (ADDR_CALC_W'(w_last) + ADDR_CALC_W'(1)) + ADDR_CALC_W'(col_cnt);
  assign pix      = 2'(pixel_value >> PIX_SHIFT) & PIX_MASK;

  always_comb begin
    stage_next             = '0;
    stage_next.valid       = 1'b1;
    stage_next.row_in_band = row_cnt[BAND_LOG-1:0];
    stage_next.emit        = (row_cnt[BAND_LOG-1:0] == BAND_BOTTOM_ROW);
    stage_next.fresh       = (row_cnt[BAND_LOG-1:0] == BAND_TOP_ROW) || (row_cnt == h_last);
    stage_next.last        = (row_cnt == '0) && (col_cnt == w_last);
    stage_next.hi          = pix[1];
    stage_next.lo          = pix[0];
    stage_next.addr        = {addr_sum[BYTE_ADDR_W-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w_last  <= COL_W'(dim_last(RESET_WIDTH, MAX_WIDTH));
      h_last  <= ROW_W'(dim_last(RESET_HEIGHT, MAX_HEIGHT));
      col_cnt <= '0;
      row_cnt <= ROW_W'(dim_last(RESET_HEIGHT, MAX_HEIGHT));
      stage   <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index_t'(cfg_index))
        CFG_IMAGE_WIDTH: begin
          w_last  <= cfg_w_last;
          row_cnt <= h_last;
        end
        CFG_IMAGE_HEIGHT: begin
          h_last  <= cfg_h_last;
          row_cnt <= cfg_h_last;
        end
        default: begin
          row_cnt <= h_last;
        end
      endcase
      col_cnt     <= '0;
      stage.valid <= 1'b0;
    end else if (accept) begin
      col_cnt <= col_cnt_next;
      row_cnt <= row_cnt_next;
      stage   <= stage_next;
    end else if (!hold) begin
      stage.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_col <= col_cnt;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ppk_emit.sv
// ----------------------------------------------------------------------------
// ppk_emit
// Merge stage: read-modify-write of the column store and the output pair.
// ----------------------------------------------------------------------------
`default_nettype none

module ppk_emit import ppk_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 128,
  localparam int unsigned COL_W    = $clog2(MAX_WIDTH)
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire stage_t                 stage,
  input  wire logic [COL_W-1:0]       stage_col,
  input  wire logic [ENTRY_W-1:0]     rd_data,
  output logic                        wr_en,
  output logic      [COL_W-1:0]       wr_addr,
  output logic      [ENTRY_W-1:0]     wr_data,
  output logic                        hold,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic      [BYTE_ADDR_W-1:0] byte_address,
  output logic      [BYTE_W-1:0]      byte_value,
  output logic                        last_of_pair,
  output logic                        frame_done
);

  typedef enum logic [2:0] {
    OUT_IDLE = 3'b001,
    OUT_HIGH = 3'b010,
    OUT_LOW  = 3'b100
  } out_state_t;

  out_state_t             out_state;
  out_state_t             out_state_next;
  logic [BYTE_ADDR_W-1:0] pair_addr;
  logic [BYTE_W-1:0]      pair_hi;
  logic [BYTE_W-1:0]      pair_lo;
  logic                   pair_done;
  logic                   fwd_valid;
  logic [COL_W-1:0]       fwd_col;
  logic [ENTRY_W-1:0]     fwd_data;
  logic [ENTRY_W-1:0]     base;
  logic [ENTRY_W-1:0]     set_bits;
  logic                   pair_free;
  logic                   go;
  logic                   out_take;

  // A write in the same cycle as the read misses the RAM (read-first); take it from here.
  always_comb begin
    if (stage.fresh) begin
      base = '0;
    end else if (fwd_valid && (fwd_col == stage_col)) begin
      base = fwd_data;
    end else begin
      base = rd_data;
    end
  end

  assign set_bits = (ENTRY_W'(stage.hi) << (stage.row_in_band - BAND_LOG'(1))) |
                    (ENTRY_W'(stage.lo) << (4'(stage.row_in_band) + 4'(PLANE_BITS - 1)));

  assign out_take  = out_valid && !out_stall;
  assign pair_free = (out_state == OUT_IDLE) || ((out_state == OUT_LOW) && !out_stall);
  assign hold      = stage.valid && stage.emit && !pair_free;
  assign go        = stage.valid && !hold;

  assign wr_en   = go;
  assign wr_addr = stage_col;
  assign wr_data = stage.emit ? '0 : (base | set_bits);

  always_comb begin
    out_state_next = out_state;
    if (go && stage.emit) begin
      out_state_next = OUT_HIGH;
    end else if (out_take) begin
      case (out_state)
        OUT_HIGH: out_state_next = OUT_LOW;
        OUT_LOW:  out_state_next = OUT_IDLE;
        default:  out_state_next = OUT_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_state <= OUT_IDLE;
      fwd_valid <= 1'b0;
    end else begin
      out_state <= out_state_next;
      if (go) begin
        fwd_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      fwd_col  <= stage_col;
      fwd_data <= wr_data;
    end
    if (go && stage.emit) begin
      pair_addr <= stage.addr;
      pair_hi   <= {base[PLANE_BITS-1:0], stage.hi};
      pair_lo   <= {base[ENTRY_W-1:PLANE_BITS], stage.lo};
      pair_done <= stage.last;
    end
  end

  assign out_valid    = (out_state != OUT_IDLE);
  assign last_of_pair = (out_state == OUT_LOW);
  assign byte_address = {pair_addr[BYTE_ADDR_W-1:1], last_of_pair};
  assign byte_value   = last_of_pair ? pair_lo : pair_hi;
  assign frame_done   = last_of_pair && pair_done;

endmodule

`default_nettype wire

FILE: hw/rtl/pixel_to_page_planar_2bpp_packer_core.sv
// ----------------------------------------------------------------------------
// pixel_to_page_planar_2bpp_packer_core
// Packs a bottom-up grey bitmap into page-organised two-plane LCD bytes.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------
//  cfg     | in        | cfg_wr_en            | cfg_index, cfg_data
//  in      | in        | in_valid / in_stall  | pixel_value
//  out     | out       | out_valid / out_stall| byte_address, byte_value,
//          |           |                      | last_of_pair, frame_done
//
//  One pixel beat is taken per cycle while in_stall is low. A pixel on the
//  bottom row of its band yields two output beats, so the output port (one
//  beat per cycle while out_stall is low) sets the rate there.
//  The stage register and the output pair lie between a pixel and its beats.
//  rst is synchronous; it sets 96 x 64, restarts the frame and empties the
//  pipe. No clearing pass over the store is needed.
//  out_stall holds the pair; in_stall rises while a bottom-row pixel waits.
//
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_to_page_planar_2bpp_packer_core import ppk_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 128,
  parameter int unsigned MAX_HEIGHT = 128
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // configuration
  input  wire logic                   cfg_wr_en,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  // pixel beats
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [PIXEL_W-1:0]     pixel_value,
  // packed byte beats
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic      [BYTE_ADDR_W-1:0] byte_address,
  output logic      [BYTE_W-1:0]      byte_value,
  output logic                        last_of_pair,
  output logic                        frame_done
);

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);

  // Column store: per column, rows 1..7 of the current band for both planes.
  // Its contents are never cleared. The first row of each band that arrives
  // (row 7 of the band, or the top image row) overwrites instead of
  // merging, so stale bits from an earlier frame or a restart never show.
  logic               rd_en;
  logic [COL_W-1:0]   rd_addr;
  logic [ENTRY_W-1:0] rd_data;
  logic               wr_en;
  logic [COL_W-1:0]   wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  stage_t             stage;
  logic [COL_W-1:0]   stage_col;
  logic               hold;

  // Address stage: count rows and columns, issue the store read.
  ppk_sched #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_sched (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .hold        (hold),
    .pixel_value (pixel_value),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .stage       (stage),
    .stage_col   (stage_col)
  );

  // Column store, one entry per column.
  ppk_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_WIDTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Merge stage: write back the entry, hand finished columns to the output.
  ppk_emit #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_emit (
    .clk          (clk),
    .rst          (rst),
    .stage        (stage),
    .stage_col    (stage_col),
    .rd_data      (rd_data),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .hold         (hold),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .byte_address (byte_address),
    .byte_value   (byte_value),
    .last_of_pair (last_of_pair),
    .frame_done   (frame_done)
  );

  // Hold the pixel side only while the finished pair cannot move on.
  assign in_stall = hold;

endmodule

`default_nettype wire

FILE: hw/rtl/ppk_checker.sv
// ----------------------------------------------------------------------------
// ppk_checker
// Port-level checks on the packer's output pairs.
// ----------------------------------------------------------------------------
`default_nettype none

module ppk_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [11:0] byte_address,
  input wire logic [7:0]  byte_value,
  input wire logic        last_of_pair,
  input wire logic        frame_done
);

  // A stalled beat keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(byte_address) &&
      $stable(byte_value) && $stable(last_of_pair) && $stable(frame_done))
    else $error("output beat changed while stalled");

  // The low-plane beat follows the high-plane beat at once, next address up.
  a_pair_follows: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_of_pair |=>
      out_valid && last_of_pair && (byte_address == 12'($past(byte_address) + 12'd1)))
    else $error("low-plane beat missing or misplaced");

  // High-plane bytes sit at even addresses, low-plane bytes at odd ones.
  a_plane_parity: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (byte_address[0] == last_of_pair))
    else $error("plane and address parity disagree");

  // End of frame is flagged on the low-plane byte only.
  a_done_on_low: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_done |-> last_of_pair)
    else $error("frame end flagged on a high-plane byte");

  // The pixel side is held only while a pair waits to go out.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |-> out_valid)
    else $error("pixel side held with no output pending");

endmodule

bind pixel_to_page_planar_2bpp_packer_core ppk_checker u_ppk_checker (.*);

`default_nettype wire
